>>> sv/btb_pkg.sv
// Shared constants, codes and transaction types of the bitmap threshold blitter.
package btb_pkg;

  localparam int SCREEN_WIDTH  = 84;
  localparam int SCREEN_HEIGHT = 48;
  localparam int FB_BYTES      = (SCREEN_WIDTH * SCREEN_HEIGHT) / 8;
  // Framebuffer split by byte-index parity: neighbor columns land in different banks.
  localparam int BANK_DEPTH    = (FB_BYTES + 1) / 2;
  localparam int BANK_AW       = $clog2(BANK_DEPTH);
  localparam int IDX_W         = 11;
  localparam int CFG_IW        = 2;
  localparam int CFG_DW        = 7;

  localparam logic [3:0] MAX_LEVEL   = 4'd14;
  localparam logic [7:0] OFFSET_POS  = 8'd10;
  localparam logic [7:0] WIDTH_POS   = 8'd18;
  localparam logic [7:0] HEIGHT_POS  = 8'd22;
  localparam logic [7:0] MIN_OFFSET  = 8'd23;
  localparam logic [7:0] POS_LAST    = 8'hFF;
  localparam logic [7:0] MASK_TOP    = 8'h80;
  localparam logic [7:0] MASK_BOTTOM = 8'h01;

  localparam logic [CFG_IW-1:0] REG_POS_X     = 2'd0;
  localparam logic [CFG_IW-1:0] REG_POS_Y     = 2'd1;
  localparam logic [CFG_IW-1:0] REG_THRESHOLD = 2'd2;

  typedef enum logic [1:0] {
    CMD_FILE  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_REJECT   = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_DRAW  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef struct packed {
    logic               en;
    logic [BANK_AW-1:0] addr;
    logic               on;
  } bank_req_t;

  typedef struct packed {
    op_t             op;
    bank_req_t [1:0] bank;
    logic [7:0]      mask;
    logic [7:0]      wdata;
    status_t         status;
    logic            done;
  } fb_req_t;

  typedef struct packed {
    logic [7:0] read_data;
    status_t    status;
    logic       done;
  } result_t;

endpackage

>>> sv/btb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module btb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

>>> sv/btb_parse.sv
// File-stream parser: header capture, clip check, row walk and framebuffer requests.
module btb_parse (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  btb_pkg::cmd_t            command,
  input  logic                     first,
  input  logic [7:0]               data_byte,
  input  logic [8:0]               address,
  input  logic                     cfg_valid,
  input  logic [btb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [btb_pkg::CFG_DW-1:0] cfg_data,
  output btb_pkg::fb_req_t         req
);
  import btb_pkg::*;

  logic [6:0] pos_x;
  logic [5:0] pos_y;
  logic [3:0] threshold;

  logic [7:0] file_position, file_position_next;
  logic [7:0] data_offset, data_offset_next;
  logic [7:0] image_width, image_width_next;
  logic       image_accepted, image_accepted_next;
  logic [7:0] row_mask, row_mask_next;
  logic [2:0] page_index, page_index_next;
  logic [6:0] column_now, column_now_next;
  logic [6:0] bytes_left_in_row, bytes_left_in_row_next;
  logic [1:0] pad_left, pad_left_next;
  logic [7:0] rows_left, rows_left_next;

  logic [3:0]       lim;
  logic [7:0]       col_a, col_b;
  logic [IDX_W-1:0] page_base, idx_a, idx_b;
  logic             ok_a, ok_b;
  logic [6:0]       half;
  logic [1:0]       pad_start;
  logic [7:0]       pos;
  logic             acc;
  logic [7:0]       rows;
  logic [6:0]       left_after;
  logic [7:0]       rows_after;
  logic             reject;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x     <= '0;
      pos_y     <= '0;
      threshold <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POS_X:     pos_x     <= cfg_data[6:0];
        REG_POS_Y:     pos_y     <= cfg_data[5:0];
        REG_THRESHOLD: threshold <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      file_position     <= '0;
      data_offset       <= '0;
      image_width       <= '0;
      image_accepted    <= 1'b0;
      row_mask          <= MASK_BOTTOM;
      page_index        <= '0;
      column_now        <= '0;
      bytes_left_in_row <= '0;
      pad_left          <= '0;
      rows_left         <= '0;
    end else begin
      file_position     <= file_position_next;
      data_offset       <= data_offset_next;
      image_width       <= image_width_next;
      image_accepted    <= image_accepted_next;
      row_mask          <= row_mask_next;
      page_index        <= page_index_next;
      column_now        <= column_now_next;
      bytes_left_in_row <= bytes_left_in_row_next;
      pad_left          <= pad_left_next;
      rows_left         <= rows_left_next;
    end
  end

  always_comb begin
    lim       = (threshold > MAX_LEVEL) ? MAX_LEVEL : threshold;
    col_a     = {1'b0, column_now};
    col_b     = col_a + 8'd1;
    page_base = IDX_W'(page_index) * IDX_W'(SCREEN_WIDTH);
    idx_a     = page_base + IDX_W'(col_a);
    idx_b     = page_base + IDX_W'(col_b);
    ok_a      = (IDX_W'(col_a) < IDX_W'(SCREEN_WIDTH)) && (idx_a < IDX_W'(FB_BYTES));
    ok_b      = (IDX_W'(col_b) < IDX_W'(SCREEN_WIDTH)) && (idx_b < IDX_W'(FB_BYTES));
    half      = image_width[7:1];
    pad_start = 2'(2'd0 - half[1:0]);
    pos       = first ? 8'd0 : file_position;
    acc       = first ? 1'b0 : image_accepted;
    rows      = first ? 8'd0 : rows_left;
    left_after = bytes_left_in_row - 7'd1;
    rows_after = rows - 8'd1;
    reject    = (data_byte == 8'd0) || image_width[0] ||
                (({2'b00, pos_x} + {1'b0, image_width}) > 9'(SCREEN_WIDTH)) ||
                ({2'b00, pos_y} < (data_byte - 8'd1)) ||
                ({1'b0, pos_y} >= 7'(SCREEN_HEIGHT)) ||
                (data_offset < MIN_OFFSET);

    file_position_next     = file_position;
    data_offset_next       = data_offset;
    image_width_next       = image_width;
    image_accepted_next    = image_accepted;
    row_mask_next          = row_mask;
    page_index_next        = page_index;
    column_now_next        = column_now;
    bytes_left_in_row_next = bytes_left_in_row;
    pad_left_next          = pad_left;
    rows_left_next         = rows_left;

    req        = '0;
    req.op     = OP_NONE;
    req.status = ST_OK;
    req.mask   = row_mask;
    req.wdata  = data_byte;

    if (accept) begin
      unique case (command) inside
        CMD_FILE: begin
          image_accepted_next = acc;
          rows_left_next      = rows;
          if (pos == OFFSET_POS) begin
            data_offset_next = data_byte;
          end else if (pos == WIDTH_POS) begin
            image_width_next = data_byte;
          end else if (pos == HEIGHT_POS) begin
            if (reject) begin
              image_accepted_next = 1'b0;
              rows_left_next      = '0;
              req.status          = ST_REJECT;
            end else if (image_width == 8'd0) begin
              image_accepted_next = 1'b0;
              rows_left_next      = '0;
              req.done            = 1'b1;
            end else begin
              image_accepted_next    = 1'b1;
              rows_left_next         = data_byte;
              page_index_next        = pos_y[5:3];
              row_mask_next          = MASK_BOTTOM << pos_y[2:0];
              column_now_next        = pos_x;
              bytes_left_in_row_next = half;
              pad_left_next          = '0;
            end
          end else if (acc && (rows != 8'd0) && (pos >= data_offset)) begin
            if (pad_left != 2'd0) begin
              pad_left_next = pad_left - 2'd1;
            end else begin
              req.op                     = OP_DRAW;
              req.bank[idx_a[0]].en      = ok_a;
              req.bank[idx_a[0]].addr    = BANK_AW'(idx_a >> 1);
              req.bank[idx_a[0]].on      = data_byte[7:4] > lim;
              req.bank[idx_b[0]].en      = ok_b;
              req.bank[idx_b[0]].addr    = BANK_AW'(idx_b >> 1);
              req.bank[idx_b[0]].on      = data_byte[3:0] > lim;
              column_now_next            = column_now + 7'd2;
              bytes_left_in_row_next     = left_after;
              if (left_after == 7'd0) begin
                // Row finished: step one screen row up and rewind the column.
                if (row_mask > MASK_BOTTOM) begin
                  row_mask_next = row_mask >> 1;
                end else begin
                  row_mask_next   = MASK_TOP;
                  page_index_next = page_index - 3'd1;
                end
                rows_left_next         = rows_after;
                column_now_next        = pos_x;
                bytes_left_in_row_next = half;
                pad_left_next          = pad_start;
                if (rows_after == 8'd0) begin
                  image_accepted_next = 1'b0;
                  pad_left_next       = '0;
                  req.done            = 1'b1;
                end
              end
            end
          end
          file_position_next = (pos != POS_LAST) ? pos + 8'd1 : pos;
        end
        CMD_WRITE, CMD_READ: begin
          if (IDX_W'(address) >= IDX_W'(FB_BYTES)) begin
            req.status = ST_BAD_ADDR;
          end else begin
            req.op                   = (command == CMD_WRITE) ? OP_WRITE : OP_READ;
            req.bank[address[0]].en   = 1'b1;
            req.bank[address[0]].addr = BANK_AW'(address >> 1);
          end
        end
        default: ;
      endcase
    end
  end

endmodule

>>> sv/btb_fbuf.sv
// Framebuffer: two parity banks, read-modify-write stage, write forwarding, clear pass.
module btb_fbuf (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  btb_pkg::fb_req_t  req,
  input  logic              advance,
  output logic              busy,
  output btb_pkg::result_t  res
);
  import btb_pkg::*;

  fb_req_t            s1;
  logic               clr_busy;
  logic [BANK_AW-1:0] clr_addr;

  logic [1:0]         lw_valid;
  logic [BANK_AW-1:0] lw_addr [2];
  logic [7:0]         lw_data [2];

  logic [1:0]         ram_we, ram_re, upd_we;
  logic [BANK_AW-1:0] ram_waddr [2];
  logic [7:0]         ram_wdata [2];
  logic [7:0]         ram_q [2];
  logic [7:0]         old [2];
  logic [7:0]         new_data [2];

  always_ff @(posedge clk) begin
    if (load) begin
      s1 <= req;
    end
  end

  // Zero both banks after reset, one entry per bank each cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      if (clr_addr == BANK_AW'(BANK_DEPTH - 1)) begin
        clr_busy <= 1'b0;
      end else begin
        clr_addr <= clr_addr + BANK_AW'(1);
      end
    end
  end

  always_comb begin
    for (int b = 0; b < 2; b++) begin
      // The read may have gone out as the bank's last write landed; take that data.
      old[b] = (lw_valid[b] && (lw_addr[b] == s1.bank[b].addr)) ? lw_data[b] : ram_q[b];
      unique case (s1.op)
        OP_DRAW: begin
          upd_we[b]   = advance && s1.bank[b].en;
          new_data[b] = s1.bank[b].on ? (old[b] | s1.mask) : (old[b] & ~s1.mask);
        end
        OP_WRITE: begin
          upd_we[b]   = advance && s1.bank[b].en;
          new_data[b] = s1.wdata;
        end
        default: begin
          upd_we[b]   = 1'b0;
          new_data[b] = old[b];
        end
      endcase
      ram_we[b]    = clr_busy || upd_we[b];
      ram_waddr[b] = clr_busy ? clr_addr : s1.bank[b].addr;
      ram_wdata[b] = clr_busy ? 8'd0 : new_data[b];
      ram_re[b]    = load && req.bank[b].en;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= '0;
    end else begin
      for (int b = 0; b < 2; b++) begin
        if (upd_we[b]) begin
          lw_valid[b] <= 1'b1;
          lw_addr[b]  <= s1.bank[b].addr;
          lw_data[b]  <= new_data[b];
        end
      end
    end
  end

  for (genvar gi = 0; gi < 2; gi++) begin : g_bank
    btb_ram #(
      .WIDTH(8),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (ram_we[gi]),
      .waddr(ram_waddr[gi]),
      .wdata(ram_wdata[gi]),
      .re   (ram_re[gi]),
      .raddr(req.bank[gi].addr),
      .rdata(ram_q[gi])
    );
  end

  always_comb begin
    res.read_data = (s1.op == OP_READ) ? (s1.bank[1].en ? old[1] : old[0]) : 8'd0;
    res.status    = s1.status;
    res.done      = s1.done;
  end

  assign busy = clr_busy;

endmodule

>>> sv/bitmap_threshold_blitter_top.sv
// Top level of the bitmap threshold blitter: handshakes, pipeline control, result register.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------------
//   item     | item_valid / item_ready    | command, first, data_byte, address
//   result   | result_valid / result_ready| read_data, status, image_done
//   config   | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One item per cycle unless the clear pass or a stalled result holds item_ready low; the
// accept cycle issues the bank reads, and the second stage does the read-modify-write of
// both parity banks and loads the result register. After reset a clear pass zeroes the
// framebuffer; item_ready stays low during it, while configuration writes are always taken.
// A stalled result holds the second stage, and item_ready then stays low until it drains.
module bitmap_threshold_blitter_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  logic [1:0]                 command,
  input  logic                       first,
  input  logic [7:0]                 data_byte,
  input  logic [8:0]                 address,
  output logic                       result_valid,
  input  logic                       result_ready,
  output logic [7:0]                 read_data,
  output logic [1:0]                 status,
  output logic                       image_done,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [btb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [btb_pkg::CFG_DW-1:0] cfg_data
);
  import btb_pkg::*;

  logic    accept;
  logic    s1_valid;
  logic    s1_adv;
  logic    busy;
  fb_req_t req;
  result_t res;

  assign s1_adv     = s1_valid && (!result_valid || result_ready);
  assign item_ready = !busy && (!s1_valid || s1_adv);
  assign accept     = item_valid && item_ready;
  assign cfg_ready  = 1'b1;

  btb_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .command  (cmd_t'(command)),
    .first    (first),
    .data_byte(data_byte),
    .address  (address),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req)
  );

  btb_fbuf u_fbuf (
    .clk    (clk),
    .rst    (rst),
    .load   (accept),
    .req    (req),
    .advance(s1_adv),
    .busy   (busy),
    .res    (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Hold the result until the downstream side takes the transaction.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_data  <= res.read_data;
      status     <= res.status;
      image_done <= res.done;
    end
  end

endmodule

>>> sim/btb_blit_checker.sv
// Checker for the bitmap threshold blitter: mirrors the framebuffer and compares every result.
module btb_blit_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  input  logic                       item_ready,
  input  logic [1:0]                 command,
  input  logic                       first,
  input  logic [7:0]                 data_byte,
  input  logic [8:0]                 address,
  input  logic                       result_valid,
  input  logic                       result_ready,
  input  logic [7:0]                 read_data,
  input  logic [1:0]                 status,
  input  logic                       image_done,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [btb_pkg::CFG_IW-1:0] cfg_index,
  input  logic [btb_pkg::CFG_DW-1:0] cfg_data,
  output int                         errors,
  output int                         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import btb_pkg::*;

  logic [7:0] fb_mem [FB_BYTES];
  logic [7:0] file_pos;
  logic [7:0] hdr_offset;
  logic [7:0] img_w;
  logic [7:0] img_h;
  logic       drawing;
  logic [7:0] bit_sel;
  logic [2:0] page;
  logic [6:0] col;
  logic [6:0] bytes_left;
  logic [1:0] pad;
  logic [7:0] rows;
  logic [6:0] cfg_x;
  logic [5:0] cfg_y;
  logic [3:0] cfg_thr;

  result_t expected_results[$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  task automatic clear_model();
    for (int i = 0; i < FB_BYTES; i++) fb_mem[i] = 8'h00;
    file_pos   = '0;
    hdr_offset = '0;
    img_w      = '0;
    img_h      = '0;
    drawing    = 1'b0;
    bit_sel    = MASK_BOTTOM;
    page       = '0;
    col        = '0;
    bytes_left = '0;
    pad        = '0;
    rows       = '0;
    cfg_x      = '0;
    cfg_y      = '0;
    cfg_thr    = '0;
  endtask

  task automatic paint(input int c, input logic [3:0] level);
    int         idx;
    logic [3:0] lim;
    idx = int'(page) * SCREEN_WIDTH + c;
    lim = (cfg_thr > MAX_LEVEL) ? MAX_LEVEL : cfg_thr;
    // drop pixels that fall off the framebuffer
    if (c < SCREEN_WIDTH && idx < FB_BYTES) begin
      if (level > lim) fb_mem[idx] = fb_mem[idx] | bit_sel;
      else fb_mem[idx] = fb_mem[idx] & ~bit_sel;
    end
  endtask

  task automatic new_row();
    col        = cfg_x;
    bytes_left = img_w[7:1];
    pad        = 2'd0 - img_w[2:1];
  endtask

  task automatic header_check(output bit rej, output bit fin);
    int w;
    int h;
    w   = int'(img_w);
    h   = int'(img_h);
    rej = 1'b0;
    fin = 1'b0;
    if (h == 0 || img_w[0] || int'(cfg_x) + w > SCREEN_WIDTH || int'(cfg_y) < h - 1 ||
        int'(cfg_y) >= SCREEN_HEIGHT || hdr_offset < MIN_OFFSET) begin
      drawing = 1'b0;
      rows    = '0;
      rej     = 1'b1;
    end else if (w == 0) begin
      drawing = 1'b0;
      rows    = '0;
      fin     = 1'b1;
    end else begin
      drawing = 1'b1;
      rows    = img_h;
      page    = cfg_y[5:3];
      bit_sel = MASK_BOTTOM << cfg_y[2:0];
      new_row();
      pad     = '0;
    end
  endtask

  task automatic draw_pair(input logic [7:0] b, output bit fin);
    fin = 1'b0;
    paint(int'(col), b[7:4]);
    paint(int'(col) + 1, b[3:0]);
    col        = col + 7'd2;
    bytes_left = bytes_left - 7'd1;
    if (bytes_left == 0) begin
      // advance one screen row up
      if (bit_sel > MASK_BOTTOM) begin
        bit_sel = bit_sel >> 1;
      end else begin
        bit_sel = MASK_TOP;
        page    = page - 3'd1;
      end
      rows = rows - 8'd1;
      new_row();
      if (rows == 0) begin
        drawing = 1'b0;
        pad     = '0;
        fin     = 1'b1;
      end
    end
  endtask

  task automatic predict_blit(input logic [1:0] cmd, input logic f, input logic [7:0] b,
                              input logic [8:0] a, output result_t res);
    logic [7:0] p;
    bit         rej;
    bit         fin;
    res = '{read_data: 8'h00, status: ST_OK, done: 1'b0};
    fin = 1'b0;
    case (cmd_t'(cmd))
      CMD_FILE: begin
        if (f) begin
          file_pos = '0;
          drawing  = 1'b0;
          rows     = '0;
        end
        p = file_pos;
        if (p == OFFSET_POS) begin
          hdr_offset = b;
        end else if (p == WIDTH_POS) begin
          img_w = b;
        end else if (p == HEIGHT_POS) begin
          img_h = b;
          header_check(rej, fin);
          if (rej) res.status = ST_REJECT;
        end else if (drawing && rows != 0 && p >= hdr_offset) begin
          if (pad != 0) pad = pad - 2'd1;
          else draw_pair(b, fin);
        end
        if (file_pos != POS_LAST) file_pos = file_pos + 8'd1;
      end
      CMD_WRITE, CMD_READ: begin
        if (a >= FB_BYTES) res.status = ST_BAD_ADDR;
        else if (cmd_t'(cmd) == CMD_WRITE) fb_mem[a] = b;
        else res.read_data = fb_mem[a];
      end
      default: ;
    endcase
    res.done = fin;
  endtask

  task automatic report(input string what, input logic [7:0] want, input logic [7:0] seen);
    errors++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, seen);
  endtask

  task automatic check_result();
    result_t want;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none, actual read_data %0h status %0h done %0h",
               $time, read_data, status, image_done);
    end else begin
      want = expected_results.pop_front();
      if (read_data !== want.read_data) report("read_data", want.read_data, read_data);
      if (status !== want.status) report("status", 8'(want.status), 8'(status));
      if (image_done !== want.done) report("image_done", 8'(want.done), 8'(image_done));
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      clear_model();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_POS_X:     cfg_x   = cfg_data[6:0];
          REG_POS_Y:     cfg_y   = cfg_data[5:0];
          REG_THRESHOLD: cfg_thr = cfg_data[3:0];
          default: ;
        endcase
      end
      if (item_valid && item_ready) begin
        predict_blit(command, first, data_byte, address, want);
        expected_results.push_back(want);
      end
      if (result_valid && result_ready) check_result();
    end
    pending = expected_results.size();
  end

endmodule

>>> sim/tb_bitmap_threshold_blitter_top.sv
// Testbench top of the bitmap threshold blitter: stimulus, stall patterns and verdict.
module tb_bitmap_threshold_blitter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import btb_pkg::*;

  localparam int ITEM_TARGET = 1250;
  localparam int LIMIT       = 600000;
  localparam int DRAIN_WAIT  = 4;

  logic              clk          = 1'b0;
  logic              rst          = 1'b1;
  logic              item_valid   = 1'b0;
  logic              item_ready;
  logic [1:0]        command      = '0;
  logic              first        = 1'b0;
  logic [7:0]        data_byte    = '0;
  logic [8:0]        address      = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [7:0]        read_data;
  logic [1:0]        status;
  logic              image_done;
  logic              cfg_valid    = 1'b0;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index    = '0;
  logic [CFG_DW-1:0] cfg_data     = '0;

  int errors;
  int pending;
  int cycles      = 0;
  int burst_left  = 0;
  int items_done  = 0;
  int rx_tick     = 0;
  int rx_mode     = 0;

  logic [6:0] cur_x   = '0;
  logic [5:0] cur_y   = '0;
  logic [3:0] cur_thr = '0;

  always #1 clk = ~clk;

  bitmap_threshold_blitter_top uut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .command      (command),
    .first        (first),
    .data_byte    (data_byte),
    .address      (address),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .read_data    (read_data),
    .status       (status),
    .image_done   (image_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  btb_blit_checker blit_check (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .command      (command),
    .first        (first),
    .data_byte    (data_byte),
    .address      (address),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .read_data    (read_data),
    .status       (status),
    .image_done   (image_done),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .errors       (errors),
    .pending      (pending)
  );

  // receiver: drive result_ready from one of four stall patterns, picked at random
  always @(posedge clk) begin
    rx_tick <= rx_tick + 1;
    if (rx_tick % 128 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0:       result_ready <= 1'b1;
      1:       result_ready <= ($urandom_range(0, 3) != 0);
      2:       result_ready <= (rx_tick % 7 < 4);
      default: result_ready <= ($urandom_range(0, 9) < 3);
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("tb_bitmap_threshold_blitter_top NOT OK");
      $finish;
    end
  end

  task automatic send_item(input cmd_t c, input logic f, input logic [7:0] b,
                           input logic [8:0] a);
    int gap;
    bit hs;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 32);
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
      if (gap != 0) begin
        item_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    item_valid <= 1'b1;
    command    <= c;
    first      <= f;
    data_byte  <= b;
    address    <= a;
    do begin
      @(negedge clk);
      hs = item_ready;
      @(posedge clk);
    end while (!hs);
    items_done++;
  endtask

  task automatic wait_cfg();
    bit hs;
    do begin
      @(negedge clk);
      hs = cfg_ready;
      @(posedge clk);
    end while (!hs);
  endtask

  task automatic write_regs(input logic [6:0] x, input logic [5:0] y, input logic [3:0] t);
    cfg_valid <= 1'b1;
    cfg_index <= REG_POS_X;
    cfg_data  <= CFG_DW'(x);
    wait_cfg();
    cfg_index <= REG_POS_Y;
    cfg_data  <= CFG_DW'(y);
    wait_cfg();
    cfg_index <= REG_THRESHOLD;
    cfg_data  <= CFG_DW'(t);
    wait_cfg();
    cfg_valid <= 1'b0;
    cur_x   = x;
    cur_y   = y;
    cur_thr = t;
  endtask

  // hold the sender until every result is back, then let the pipeline settle
  task automatic drain();
    item_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic logic [3:0] gray_level();
    case ($urandom_range(0, 5))
      0:       return 4'h0;
      1:       return 4'hF;
      2:       return cur_thr;
      3:       return cur_thr + 4'd1;
      4:       return MAX_LEVEL;
      default: return 4'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic logic [7:0] pixel_pair();
    return {gray_level(), gray_level()};
  endfunction

  // one bitmap file: header fields at their positions, then rows with padding
  task automatic send_file(input logic f, input logic [7:0] off, input logic [7:0] w,
                           input logic [7:0] h, input int cut);
    int         half;
    int         row_len;
    int         start;
    int         len;
    logic [7:0] b;
    bit         useful;
    half    = w / 2;
    row_len = half + (4 - half % 4) % 4;
    start   = (off < MIN_OFFSET) ? int'(MIN_OFFSET) : int'(off);
    len     = start + int'(h) * row_len;
    if (cut >= 0 && cut < len) len = cut;
    for (int pos = 0; pos < len; pos++) begin
      useful = (pos >= start);
      b = useful ? pixel_pair() : 8'($urandom_range(0, 255));
      if (pos == int'(OFFSET_POS)) b = off;
      else if (pos == int'(WIDTH_POS)) b = w;
      else if (pos == int'(HEIGHT_POS)) b = h;
      send_item(CMD_FILE, (pos == 0) ? f : 1'b0, b, 9'($urandom_range(0, 511)));
    end
  endtask

  function automatic int fit_w(input int cap);
    int w_max;
    w_max = (int'(cur_x) >= SCREEN_WIDTH) ? 0 : (SCREEN_WIDTH - int'(cur_x)) & ~1;
    if (w_max > cap) w_max = cap;
    return 2 * $urandom_range(0, w_max / 2);
  endfunction

  function automatic int fit_h(input int cap);
    int h_max;
    h_max = (int'(cur_y) >= SCREEN_HEIGHT) ? 1 : int'(cur_y) + 1;
    if (h_max > cap) h_max = cap;
    return $urandom_range(1, h_max);
  endfunction

  function automatic logic [7:0] pick_offset();
    int r;
    r = $urandom_range(0, 49);
    if (r == 0) return 8'($urandom_range(200, 255));
    if (r < 12) return MIN_OFFSET + 8'($urandom_range(1, 8));
    return MIN_OFFSET;
  endfunction

  task automatic read_at(input int a);
    send_item(CMD_READ, 1'b0, 8'($urandom_range(0, 255)), 9'(a));
  endtask

  // draw an image, then, if it fits the screen, read back three bytes of its area
  task automatic draw_image(input int w, input int h, input int cut);
    int lo;
    int pg;
    send_file(1'b1, pick_offset(), 8'(w), 8'(h), cut);
    if (cut < 0) begin
      repeat ($urandom_range(0, 2))
        send_item(CMD_FILE, 1'b0, 8'($urandom_range(0, 255)), 9'($urandom_range(0, 511)));
    end
    if (w > 0 && int'(cur_y) < SCREEN_HEIGHT && int'(cur_x) + w <= SCREEN_WIDTH) begin
      lo = int'(cur_y) - h + 1;
      if (lo < 0) lo = 0;
      repeat (3) begin
        pg = $urandom_range(lo / 8, int'(cur_y) / 8);
        read_at(pg * SCREEN_WIDTH + int'(cur_x) + $urandom_range(0, w - 1));
      end
    end
  endtask

  task automatic send_rejected();
    logic [7:0] off;
    int         w;
    int         h;
    int         base;
    off = MIN_OFFSET;
    w   = 2;
    h   = 1;
    case ($urandom_range(0, 4))
      0: h = 0;
      1: w = 2 * $urandom_range(0, 40) + 1;
      2: begin
        base = (int'(cur_x) >= SCREEN_WIDTH) ? 0 : (SCREEN_WIDTH - int'(cur_x)) & ~1;
        w = base + 2 * $urandom_range(1, 4);
      end
      3: h = int'(cur_y) + 2 + $urandom_range(0, 10);
      default: off = 8'($urandom_range(0, 22));
    endcase
    send_file(1'b1, off, 8'(w), 8'(h), int'(MIN_OFFSET) + $urandom_range(0, 4));
  endtask

  task automatic fb_traffic();
    cmd_t c;
    int   r;
    int   a;
    repeat ($urandom_range(2, 8)) begin
      r = $urandom_range(0, 7);
      c = (r == 0) ? CMD_NONE : (r < 4) ? CMD_WRITE : CMD_READ;
      a = ($urandom_range(0, 5) == 0) ? $urandom_range(FB_BYTES, 511) :
                                        $urandom_range(0, FB_BYTES - 1);
      send_item(c, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)), 9'(a));
    end
  endtask

  task automatic loose_bytes(input int n);
    repeat (n)
      send_item(CMD_FILE, 1'b0, pixel_pair(), 9'($urandom_range(0, 511)));
  endtask

  initial begin
    int sel;
    int pick;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: corner image sent without a start mark, framebuffer edges
    write_regs(7'd82, 6'd47, 4'd15);
    send_file(1'b0, MIN_OFFSET, 8'd2, 8'd1, -1);
    read_at(5 * SCREEN_WIDTH + 82);
    read_at(FB_BYTES - 1);
    send_item(CMD_WRITE, 1'b0, 8'hFF, 9'd0);
    read_at(0);
    send_item(CMD_WRITE, 1'b1, 8'hA5, 9'(FB_BYTES - 1));
    read_at(FB_BYTES - 1);
    send_item(CMD_WRITE, 1'b0, 8'h5A, 9'(FB_BYTES));
    read_at(511);
    send_item(CMD_NONE, 1'b1, 8'hFF, 9'h1FF);
    read_at(256);

    // empty image and each rejection reason
    drain();
    write_regs(7'd0, 6'd0, 4'd0);
    send_file(1'b1, MIN_OFFSET, 8'd0, 8'd1, -1);
    send_file(1'b1, MIN_OFFSET, 8'd2, 8'd0, 24);
    send_file(1'b1, MIN_OFFSET, 8'd3, 8'd1, 24);
    send_file(1'b1, MIN_OFFSET, 8'd86, 8'd1, 24);
    send_file(1'b1, MIN_OFFSET, 8'd2, 8'd2, 24);
    send_file(1'b1, MIN_OFFSET - 8'd1, 8'd2, 8'd1, 24);
    drain();
    write_regs(7'd0, 6'd63, 4'd14);
    send_file(1'b1, MIN_OFFSET, 8'd2, 8'd1, 24);

    // move the image sideways mid-file so pixels fall off the right edge and wrap
    drain();
    write_regs(7'd0, 6'd7, 4'd7);
    send_file(1'b1, MIN_OFFSET, 8'd8, 8'd4, int'(MIN_OFFSET) + 4);
    drain();
    write_regs(7'd80, 6'd7, 4'd7);
    loose_bytes(4);
    drain();
    write_regs(7'd127, 6'd7, 4'd7);
    loose_bytes(8);
    read_at(0);
    read_at(1);
    read_at(80);
    read_at(83);

    // widest and tallest images
    drain();
    write_regs(7'd0, 6'd47, 4'd9);
    draw_image(SCREEN_WIDTH, 1, -1);
    draw_image(2, SCREEN_HEIGHT, -1);

    items_done = 0;
    while (items_done < ITEM_TARGET) begin
      drain();
      if ($urandom_range(0, 4) == 0) begin
        pick = $urandom_range(0, 5);
        case (pick)
          0:       write_regs(7'd0, 6'd0, 4'd0);
          1:       write_regs(7'd127, 6'd63, 4'd15);
          2:       write_regs(7'd0, 6'd47, 4'd14);
          3:       write_regs(7'd82, 6'd47, 4'd15);
          4:       write_regs(7'd0, 6'd47, 4'd0);
          default: write_regs(7'd83, 6'd0, 4'd1);
        endcase
      end else begin
        write_regs(($urandom_range(0, 1) != 0) ? 7'($urandom_range(0, 127)) :
                                                 7'($urandom_range(0, 60)),
                   ($urandom_range(0, 1) != 0) ? 6'($urandom_range(0, 63)) :
                                                 6'($urandom_range(8, 47)),
                   4'($urandom_range(0, 15)));
      end
      repeat ($urandom_range(3, 7)) begin
        sel = $urandom_range(0, 99);
        if (sel < 50) draw_image(fit_w(16), fit_h(8), -1);
        else if (sel < 60) send_rejected();
        else if (sel < 68) draw_image(fit_w(16), fit_h(8),
                                      int'(MIN_OFFSET) + $urandom_range(0, 24));
        else if (sel < 83) fb_traffic();
        else if (sel < 90) loose_bytes($urandom_range(1, 8));
        else if (sel < 95) draw_image(fit_w(SCREEN_WIDTH), fit_h(2), -1);
        else draw_image(fit_w(2), fit_h(SCREEN_HEIGHT), -1);
      end
    end

    drain();
    if (errors == 0) begin
      $display("tb_bitmap_threshold_blitter_top OK");
    end else begin
      $display("tb_bitmap_threshold_blitter_top NOT OK");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/btb_pkg.sv
sv/btb_ram.sv
sv/btb_parse.sv
sv/btb_fbuf.sv
sv/bitmap_threshold_blitter_top.sv
sim/btb_blit_checker.sv
sim/tb_bitmap_threshold_blitter_top.sv
